@@ src/lidar_cliff_run_filter_top_defines.svh @@
// Assertion macros for the lidar cliff run filter.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef LIDAR_CLIFF_RUN_FILTER_TOP_DEFINES_SVH
`define LIDAR_CLIFF_RUN_FILTER_TOP_DEFINES_SVH

// same-cycle implication
`define LCRF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcrf assertion failed");

// next-cycle implication
`define LCRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcrf assertion failed");

`endif

@@ src/lcrf_pkg.sv @@
// Shared types, constants and helpers for the lidar cliff run filter.
// No dependencies; imported by lcrf_cfg, lcrf_ctrl, lcrf_dp and the top level.
package lcrf_pkg;

    localparam int SCAN_LEN  = 1024;
    localparam int MAX_RUN   = 32;
    localparam int TBL_DEPTH = 1024;
    localparam int EFF_LEN   = (SCAN_LEN > TBL_DEPTH) ? TBL_DEPTH : SCAN_LEN;
    localparam int POS_W     = $clog2(TBL_DEPTH);
    localparam int RUN_W     = $clog2(MAX_RUN + 1);
    localparam int RANGE_W   = 16;
    localparam int BLK_W     = 11;

    localparam logic [RANGE_W-1:0] NO_RETURN = '1;
    localparam logic [BLK_W-1:0]   BLK_MAX   = '1;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_SAMPLE = 2'd1,
        ACT_TICK   = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        CFG_MARGIN    = 3'd0,
        CFG_MIN_RUN   = 3'd1,
        CFG_FS_EN     = 3'd2,
        CFG_FS_DIST   = 3'd3,
        CFG_FS_LIMIT  = 3'd4,
        CFG_FS_TMO    = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_BURST_RD,
        ST_BURST_EMIT,
        ST_CUR_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic [8:0]  cliff_margin_mm;
        logic [5:0]  min_run_len;
        logic        failsafe_enable;
        logic [13:0] failsafe_dist_mm;
        logic [10:0] failsafe_count_limit;
        logic [15:0] failsafe_timeout_ticks;
    } cfg_t;

    // controller -> datapath
    typedef struct packed {
        logic take_load;
        logic take_tick;
        logic take_sample;
        logic eval;
        logic emit_now;
        logic burst_rd;
        logic burst_emit;
        logic cur_emit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        action_t action;
        logic    plan_burst;
        logic    plan_cur;
        logic    out_free;
        logic    burst_last;
        logic    with_cur;
    } status_t;

    // result payload, packed in tdata order (lowest field last)
    typedef struct packed {
        logic               failsafe_active;
        logic               stop_request;
        logic               scan_done;
        logic [RANGE_W-1:0] range_out_mm;
        logic [POS_W-1:0]   sample_index;
    } res_t;

    function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
        if (32'(p) >= EFF_LEN - 1)
            return '0;
        else
            return p + 1'b1;
    endfunction

endpackage

@@ src/lcrf_cfg.sv @@
// Configuration register file for the lidar cliff run filter.
// Depends on lcrf_pkg.
module lcrf_cfg
    import lcrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MARGIN:   cfg_next.cliff_margin_mm        = cfg_data[8:0];
                CFG_MIN_RUN:  cfg_next.min_run_len            = cfg_data[5:0];
                CFG_FS_EN:    cfg_next.failsafe_enable        = cfg_data[0];
                CFG_FS_DIST:  cfg_next.failsafe_dist_mm       = cfg_data[13:0];
                CFG_FS_LIMIT: cfg_next.failsafe_count_limit   = cfg_data[10:0];
                CFG_FS_TMO:   cfg_next.failsafe_timeout_ticks = cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cliff_margin_mm        <= 9'd200;
            cfg_reg.min_run_len            <= 6'd5;
            cfg_reg.failsafe_enable        <= 1'b1;
            cfg_reg.failsafe_dist_mm       <= 14'd200;
            cfg_reg.failsafe_count_limit   <= 11'd410;
            cfg_reg.failsafe_timeout_ticks <= 16'd2000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ src/lcrf_ctrl.sv @@
// Sequencing state machine for the lidar cliff run filter.
// Depends on lcrf_pkg; drives commands into lcrf_dp.
module lcrf_ctrl
    import lcrf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    unique case (status.action)
                        ACT_LOAD:   cmd.take_load = 1'b1;
                        ACT_TICK:   cmd.take_tick = 1'b1;
                        ACT_SAMPLE:
                        begin
                            cmd.take_sample = 1'b1;
                            state_next      = ST_EVAL;
                        end
                        default:    ;
                    endcase
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                priority if (status.plan_burst)
                    state_next = ST_BURST_RD;
                else if (status.plan_cur && status.out_free)
                begin
                    cmd.emit_now = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (status.plan_cur)
                    state_next = ST_CUR_EMIT;
                else
                    state_next = ST_IDLE;
            end
            ST_BURST_RD:
            begin
                cmd.burst_rd = 1'b1;
                state_next   = ST_BURST_EMIT;
            end
            ST_BURST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.burst_emit = 1'b1;
                    priority if (!status.burst_last)
                        state_next = ST_BURST_RD;
                    else if (status.with_cur)
                        state_next = ST_CUR_EMIT;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_CUR_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.cur_emit = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

@@ src/lcrf_dp.sv @@
// Datapath of the lidar cliff run filter: threshold table, run tracking,
// failsafe counters and the output register. Depends on lcrf_pkg.
module lcrf_dp
    import lcrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tuser
);

    logic [RANGE_W-1:0] thr_mem [TBL_DEPTH];

    logic [POS_W-1:0]   in_entry;
    logic [RANGE_W-1:0] in_value;

    logic [POS_W-1:0]   scan_pos_reg,   scan_pos_next;
    logic [POS_W-1:0]   run_start_reg,  run_start_next;
    logic [RUN_W-1:0]   run_len_reg,    run_len_next;
    logic               confirmed_reg,  confirmed_next;
    logic [BLK_W-1:0]   blk_cnt_reg,    blk_cnt_next;
    logic [15:0]        ticks_reg,      ticks_next;
    logic               active_reg,     active_next;
    logic [RANGE_W-1:0] value_reg,      value_next;
    logic               last_reg,       last_next;
    logic [RANGE_W-1:0] rd_data_reg;
    logic [POS_W-1:0]   burst_p_reg,    burst_p_next;
    logic [RUN_W-1:0]   burst_cnt_reg,  burst_cnt_next;
    logic               burst_cliff_reg, burst_cliff_next;
    logic               with_cur_reg,   with_cur_next;
    logic [POS_W-1:0]   cur_pos_reg,    cur_pos_next;
    logic [RANGE_W-1:0] cur_range_reg,  cur_range_next;
    logic               cur_cliff_reg,  cur_cliff_next;
    logic               stop_reg,       stop_next;
    logic               out_valid_reg,  out_valid_next;
    res_t               out_res_reg,    out_res_next;
    logic               out_last_reg,   out_last_next;
    logic               out_cliff_reg,  out_cliff_next;

    logic               rd_en;
    logic [POS_W-1:0]   rd_addr;
    logic [RANGE_W:0]   ev_limit;
    logic               ev_cliff;
    logic [RUN_W-1:0]   ev_minr;
    logic [RUN_W-1:0]   ev_len1;
    logic [POS_W-1:0]   ev_start1;
    logic               ev_flush;
    logic [BLK_W-1:0]   ev_blk_new;
    logic               burst_fin;

    assign in_entry = s_tdata[11:2];
    assign in_value = s_tdata[27:12];

    // threshold table: one write port for loads, one registered read port
    assign rd_en   = cmd.take_sample | cmd.burst_rd;
    assign rd_addr = cmd.burst_rd ? burst_p_reg : scan_pos_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take_load)
            thr_mem[in_entry] <= in_value;
        if (rd_en)
            rd_data_reg <= thr_mem[rd_addr];
    end

    // evaluation of the captured sample against its beam threshold
    always_comb
    begin
        ev_limit  = {1'b0, rd_data_reg} + (RANGE_W + 1)'(cfg.cliff_margin_mm);
        ev_cliff  = {1'b0, value_reg} > ev_limit;
        if (32'(cfg.min_run_len) > MAX_RUN)
            ev_minr = RUN_W'(MAX_RUN);
        else
            ev_minr = RUN_W'(cfg.min_run_len);
        ev_len1   = run_len_reg + 1'b1;
        ev_start1 = (run_len_reg == '0) ? scan_pos_reg : run_start_reg;
        ev_flush  = (ev_len1 >= ev_minr) || last_reg;
        ev_blk_new = blk_cnt_reg;
        if (!ev_cliff && (value_reg < RANGE_W'(cfg.failsafe_dist_mm))
            && (blk_cnt_reg != BLK_MAX))
            ev_blk_new = blk_cnt_reg + 1'b1;
    end

    assign status.action     = action_t'(s_tdata[1:0]);
    assign status.plan_burst = ev_cliff ? (!confirmed_reg && ev_flush)
                                        : (!confirmed_reg && (run_len_reg != '0));
    assign status.plan_cur   = !ev_cliff || confirmed_reg;
    assign status.out_free   = !out_valid_reg || m_tready;
    assign status.burst_last = (burst_cnt_reg == RUN_W'(1));
    assign status.with_cur   = with_cur_reg;

    always_comb
    begin
        scan_pos_next    = scan_pos_reg;
        run_start_next   = run_start_reg;
        run_len_next     = run_len_reg;
        confirmed_next   = confirmed_reg;
        blk_cnt_next     = blk_cnt_reg;
        ticks_next       = ticks_reg;
        active_next      = active_reg;
        value_next       = value_reg;
        last_next        = last_reg;
        burst_p_next     = burst_p_reg;
        burst_cnt_next   = burst_cnt_reg;
        burst_cliff_next = burst_cliff_reg;
        with_cur_next    = with_cur_reg;
        cur_pos_next     = cur_pos_reg;
        cur_range_next   = cur_range_reg;
        cur_cliff_next   = cur_cliff_reg;
        stop_next        = stop_reg;

        if (cmd.take_tick && (ticks_reg != '1))
            ticks_next = ticks_reg + 1'b1;

        if (cmd.take_sample)
        begin
            value_next = in_value;
            last_next  = s_tlast;
        end

        if (cmd.eval)
        begin
            cur_pos_next   = scan_pos_reg;
            stop_next      = 1'b0;
            burst_cnt_next = '0;
            with_cur_next  = 1'b0;
            if (ev_cliff)
            begin
                if (confirmed_reg)
                begin
                    with_cur_next  = 1'b1;
                    cur_range_next = rd_data_reg;
                    cur_cliff_next = 1'b1;
                end
                else if (ev_flush)
                begin
                    burst_p_next     = ev_start1;
                    burst_cnt_next   = ev_len1;
                    burst_cliff_next = 1'b1;
                    run_len_next     = '0;
                    confirmed_next   = 1'b1;
                end
                else
                begin
                    run_len_next   = ev_len1;
                    run_start_next = ev_start1;
                end
            end
            else
            begin
                // a short run ended by this sample goes out as non-cliff
                burst_p_next     = run_start_reg;
                burst_cnt_next   = confirmed_reg ? '0 : run_len_reg;
                burst_cliff_next = 1'b0;
                with_cur_next    = 1'b1;
                cur_range_next   = NO_RETURN;
                cur_cliff_next   = 1'b0;
                run_len_next     = '0;
                confirmed_next   = 1'b0;
                blk_cnt_next     = ev_blk_new;
            end

            if (last_reg)
            begin
                if (cfg.failsafe_enable)
                begin
                    if (ev_blk_new >= cfg.failsafe_count_limit)
                    begin
                        if (ticks_reg > cfg.failsafe_timeout_ticks)
                        begin
                            stop_next   = 1'b1;
                            active_next = 1'b1;
                        end
                    end
                    else
                    begin
                        ticks_next  = '0;
                        active_next = 1'b0;
                    end
                end
                scan_pos_next  = '0;
                run_start_next = '0;
                run_len_next   = '0;
                confirmed_next = 1'b0;
                blk_cnt_next   = '0;
            end
            else
            begin
                scan_pos_next = next_pos(scan_pos_reg);
            end
        end

        if (cmd.burst_emit)
        begin
            burst_p_next   = next_pos(burst_p_reg);
            burst_cnt_next = burst_cnt_reg - 1'b1;
        end
    end

    // output register
    assign burst_fin = status.burst_last && !with_cur_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_res_next   = out_res_reg;
        out_last_next  = out_last_reg;
        out_cliff_next = out_cliff_reg;
        priority if (cmd.emit_now)
        begin
            out_valid_next               = 1'b1;
            out_res_next.sample_index    = scan_pos_reg;
            out_res_next.range_out_mm    = ev_cliff ? rd_data_reg : NO_RETURN;
            out_res_next.scan_done       = last_reg;
            out_res_next.stop_request    = stop_next;
            out_res_next.failsafe_active = active_next;
            out_last_next                = 1'b1;
            out_cliff_next               = ev_cliff;
        end
        else if (cmd.burst_emit)
        begin
            out_valid_next               = 1'b1;
            out_res_next.sample_index    = burst_p_reg;
            out_res_next.range_out_mm    = burst_cliff_reg ? rd_data_reg : NO_RETURN;
            out_res_next.scan_done       = burst_fin && last_reg;
            out_res_next.stop_request    = burst_fin && stop_reg;
            out_res_next.failsafe_active = active_reg;
            out_last_next                = burst_fin;
            out_cliff_next               = burst_cliff_reg;
        end
        else if (cmd.cur_emit)
        begin
            out_valid_next               = 1'b1;
            out_res_next.sample_index    = cur_pos_reg;
            out_res_next.range_out_mm    = cur_range_reg;
            out_res_next.scan_done       = last_reg;
            out_res_next.stop_request    = stop_reg;
            out_res_next.failsafe_active = active_reg;
            out_last_next                = 1'b1;
            out_cliff_next               = cur_cliff_reg;
        end
        else
        begin
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_pos_reg  <= '0;
            run_start_reg <= '0;
            run_len_reg   <= '0;
            confirmed_reg <= 1'b0;
            blk_cnt_reg   <= '0;
            ticks_reg     <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            scan_pos_reg  <= scan_pos_next;
            run_start_reg <= run_start_next;
            run_len_reg   <= run_len_next;
            confirmed_reg <= confirmed_next;
            blk_cnt_reg   <= blk_cnt_next;
            ticks_reg     <= ticks_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg       <= value_next;
        last_reg        <= last_next;
        burst_p_reg     <= burst_p_next;
        burst_cnt_reg   <= burst_cnt_next;
        burst_cliff_reg <= burst_cliff_next;
        with_cur_reg    <= with_cur_next;
        cur_pos_reg     <= cur_pos_next;
        cur_range_reg   <= cur_range_next;
        cur_cliff_reg   <= cur_cliff_next;
        stop_reg        <= stop_next;
        out_res_reg     <= out_res_next;
        out_last_reg    <= out_last_next;
        out_cliff_reg   <= out_cliff_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(32 - $bits(res_t))'(0), out_res_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_cliff_reg;

endmodule

@@ src/lidar_cliff_run_filter_top.sv @@
// Lidar cliff run filter. Load items fill the 1024-entry beam threshold
// table, tick items advance the failsafe timer, sample items are compared
// against threshold plus margin. A sample that answers at once or holds back
// reads the table when accepted, then decides and, if it answers, loads the
// output register. A released run rereads each held point's threshold through
// the single table read port and emits it once the output register is free.
// The output register lets the next item enter while the last result waits.
// Results carry the scan position they answer; tlast marks the last result of
// an item, and scan_done/stop_request/failsafe_active ride in tdata.
// Depends on lcrf_pkg, lcrf_cfg, lcrf_ctrl and lcrf_dp.
module lidar_cliff_run_filter_top
    import lcrf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // action[1:0], entry_index[11:2], value_mm[27:12]
    input  logic        s_axis_tlast,   // scan_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // sample_index[9:0], range_out_mm[25:10],
                                        // scan_done[26], stop_request[27],
                                        // failsafe_active[28]
    output logic        m_axis_tlast,   // last_of_burst
    output logic        m_axis_tuser,   // is_cliff
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    lcrf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lcrf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lcrf_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_axis_tdata),
        .s_tlast  (s_axis_tlast),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tlast  (m_axis_tlast),
        .m_tuser  (m_axis_tuser)
    );

endmodule

@@ src/lcrf_checker.sv @@
// Port-level checks for the lidar cliff run filter, bound to the top level.
// Depends on lidar_cliff_run_filter_top_defines.svh.
`include "lidar_cliff_run_filter_top_defines.svh"

module lcrf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [2:0]  cfg_index,
    input logic [15:0] cfg_data
);

    // a stalled result holds
    `LCRF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // stop request only on the closing result
    `LCRF_ASSERT_NOW(a_stop_on_done, m_axis_tvalid && m_axis_tdata[27], m_axis_tdata[26])

    // the closing result is always the last of its item
    `LCRF_ASSERT_NOW(a_done_is_last, m_axis_tvalid && m_axis_tdata[26], m_axis_tlast)

    // non-cliff results always report no return
    `LCRF_ASSERT_NOW(a_noncliff_range, m_axis_tvalid && !m_axis_tuser,
        m_axis_tdata[25:10] == 16'hFFFF)

endmodule

bind lidar_cliff_run_filter_top lcrf_checker u_lcrf_checker (.*);
